>>> src/ocs_pkg.sv
// Shared types, signature constants and helper functions for the Ogg codec sniffer.
package ocs_pkg;

  localparam int SIG_COUNT = 4;
  localparam int MAX_SIG   = 8;
  localparam logic [4:0] SEG_POS = 5'd26;
  localparam logic [4:0] MAGIC_LEN = 5'd4;

  typedef enum logic [2:0] {
    CODEC_UNKNOWN = 3'd0,
    CODEC_OPUS    = 3'd1,
    CODEC_VORBIS  = 3'd2,
    CODEC_SPEEX   = 3'd3,
    CODEC_FLAC    = 3'd4
  } codec_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } win_ctl_t;

  // newest byte of a signature sits in the low byte
  localparam logic [SIG_COUNT-1:0][63:0] SIG_TEXT = {
    64'(32'("flac")),
    64'(40'("speex")),
    64'(48'("vorbis")),
    64'("opushead")
  };

  localparam int SIG_LEN [SIG_COUNT] = '{8, 6, 5, 4};

  function automatic logic [7:0] magic_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = "O";
      2'd1:    c = "g";
      2'd2:    c = "g";
      default: c = "S";
    endcase
    return c;
  endfunction

  function automatic logic [7:0] fold_char(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c inside {["A":"Z"]}) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

endpackage

>>> src/ocs_cell.sv
// One window cell: holds a payload byte, shifts it on, and checks it against the signatures.
module ocs_cell
  import ocs_pkg::*;
#(
  parameter int POS = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  win_ctl_t             win_ctl,
  input  logic [7:0]           byte_in,
  input  logic                 valid_in,
  output logic [7:0]           byte_out,
  output logic                 valid_out,
  output logic [SIG_COUNT-1:0] hit
);

  localparam int P = (POS < MAX_SIG) ? POS : 0;

  logic [7:0] byte_r;
  logic       valid_r;
  logic       valid_nxt;

  always_comb begin
    valid_nxt = valid_r;
    if (win_ctl.clear) begin
      valid_nxt = 1'b0;
    end else if (win_ctl.shift) begin
      valid_nxt = valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (win_ctl.shift) begin
      byte_r <= byte_in;
    end
  end

  // compare the byte arriving this beat, so hits reflect the shifted window
  always_comb begin
    for (int s = 0; s < SIG_COUNT; s++) begin
      if (POS < SIG_LEN[s]) begin
        hit[s] = valid_in && (byte_in == SIG_TEXT[s][P*8 +: 8]);
      end else begin
        hit[s] = 1'b1;
      end
    end
  end

  assign byte_out  = byte_r;
  assign valid_out = valid_r;

endmodule

>>> src/ocs_ctrl.sv
// Page parser: header, lacing and payload phases, found flags and the codec decision.
module ocs_ctrl
  import ocs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  input  logic [SIG_COUNT-1:0] hits,
  output win_ctl_t             win_ctl,
  output logic                 res_valid,
  output codec_t               res_code
);

  typedef enum logic [3:0] {
    PH_HEADER  = 4'b0001,
    PH_LACING  = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_DROP    = 4'b1000
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic [4:0]            hdr_cnt_r, hdr_cnt_nxt;
  logic [7:0]            seg_left_r, seg_left_nxt;
  logic [15:0]           pay_left_r, pay_left_nxt;
  logic [SIG_COUNT-1:0]  found_r, found_nxt;
  logic                  fin;
  logic                  rearm;
  logic [15:0]           pay_sum;
  logic [15:0]           pay_dec;
  codec_t                code;

  function automatic codec_t decide(input logic [SIG_COUNT-1:0] f);
    codec_t c;
    if (f[0]) begin
      c = CODEC_OPUS;
    end else if (f[1]) begin
      c = CODEC_VORBIS;
    end else if (f[2]) begin
      c = CODEC_SPEEX;
    end else if (f[3]) begin
      c = CODEC_FLAC;
    end else begin
      c = CODEC_UNKNOWN;
    end
    return c;
  endfunction

  assign pay_sum = pay_left_r + {8'd0, data_byte};
  assign pay_dec = pay_left_r - 16'd1;

  always_comb begin
    phase_nxt    = phase_r;
    hdr_cnt_nxt  = hdr_cnt_r;
    seg_left_nxt = seg_left_r;
    pay_left_nxt = pay_left_r;
    found_nxt    = found_r;
    fin          = 1'b0;
    rearm        = 1'b0;
    code         = CODEC_UNKNOWN;
    if (step) begin
      case (phase_r)
        PH_HEADER: begin
          if (hdr_cnt_r < MAGIC_LEN && data_byte != magic_char(hdr_cnt_r[1:0])) begin
            fin = 1'b1;
          end else if (hdr_cnt_r == SEG_POS) begin
            seg_left_nxt = data_byte;
            pay_left_nxt = 16'd0;
            if (data_byte == 8'd0) begin
              fin = 1'b1;
            end else begin
              phase_nxt   = PH_LACING;
              hdr_cnt_nxt = 5'd0;
              fin         = last_byte;
            end
          end else begin
            hdr_cnt_nxt = hdr_cnt_r + 5'd1;
            fin         = last_byte;
          end
        end
        PH_LACING: begin
          pay_left_nxt = pay_sum;
          seg_left_nxt = seg_left_r - 8'd1;
          if (seg_left_nxt == 8'd0) begin
            if (pay_sum == 16'd0) begin
              fin = 1'b1;
            end else begin
              phase_nxt = PH_PAYLOAD;
              fin       = last_byte;
            end
          end else begin
            fin = last_byte;
          end
        end
        PH_PAYLOAD: begin
          found_nxt    = found_r | hits;
          pay_left_nxt = pay_dec;
          if (pay_dec == 16'd0) begin
            fin  = 1'b1;
            code = decide(found_nxt);
          end else begin
            fin = last_byte;
          end
        end
        default: begin
          rearm = last_byte;
        end
      endcase
      if (fin) begin
        if (last_byte) begin
          rearm = 1'b1;
        end else begin
          phase_nxt = PH_DROP;
        end
      end
      if (rearm) begin
        phase_nxt    = PH_HEADER;
        hdr_cnt_nxt  = 5'd0;
        seg_left_nxt = 8'd0;
        pay_left_nxt = 16'd0;
        found_nxt    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HEADER;
      hdr_cnt_r  <= 5'd0;
      seg_left_r <= 8'd0;
      pay_left_r <= 16'd0;
      found_r    <= '0;
    end else begin
      phase_r    <= phase_nxt;
      hdr_cnt_r  <= hdr_cnt_nxt;
      seg_left_r <= seg_left_nxt;
      pay_left_r <= pay_left_nxt;
      found_r    <= found_nxt;
    end
  end

  assign win_ctl.shift = step && (phase_r == PH_PAYLOAD);
  assign win_ctl.clear = rearm;
  assign res_valid     = step && fin;
  assign res_code      = code;

  a_hdr_range: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_cnt_r <= SEG_POS)
    else $error("header count past segment byte");

  a_pay_live: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (pay_left_r != 16'd0))
    else $error("payload phase with no bytes left");

  a_lace_live: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_LACING) |-> (seg_left_r != 8'd0))
    else $error("lacing phase with no segments left");

  a_rearm_clear: assert property (@(posedge clk) disable iff (!rst_n)
    rearm |=> (phase_r == PH_HEADER && found_r == '0 && hdr_cnt_r == 5'd0))
    else $error("rearm did not restore header phase");

endmodule

>>> src/ocs_outq.sv
// Two-entry result queue between the parser and the output channel.
module ocs_outq
  import ocs_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   wr_en,
  input  codec_t wr_code,
  input  logic   rd_en,
  output logic   full,
  output logic   not_empty,
  output codec_t rd_code
);

  codec_t     mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign pop        = rd_en && (cnt_r != 2'd0);
  assign wr_ptr_nxt = wr_en ? !wr_ptr_r : wr_ptr_r;
  assign rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
  assign cnt_nxt    = cnt_r + {1'b0, wr_en} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_code;
    end
  end

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign rd_code   = mem_r[rd_ptr_r];

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !full)
    else $error("write into full result queue");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2)
    else $error("result queue count out of range");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");

endmodule

>>> src/ogg_codec_sniffer_unit.sv
// Ogg codec sniffer: parses the first page and reports the codec found in its payload.
//
// Input channel: one file byte per beat (in_data_byte) with in_last_byte on the
// final byte. Output channel: one codec code per file (out_codec_kind):
// 0 unknown, 1 opus, 2 vorbis, 3 speex, 4 flac.
// A new byte is accepted every cycle while in_stall is low.
// The per-byte work is an update of the page counters and a shift of
// the payload window, a row of cells each comparing its byte to the signatures.
// Each result is registered in the result queue and offered on the output from there.
// Bytes after the answer are dropped until the last-byte mark; the block then
// rearms for the next file. A bad magic, empty page or early end gives unknown.
// Results wait in a two-entry queue; in_stall rises only when both entries
// are held because the receiver stalls, and falls as soon as one is taken.
// Reset (rst_n low, synchronous) empties the queue and returns to the header.
module ogg_codec_sniffer_unit
  import ocs_pkg::*;
#(
  parameter int WINDOW_DEPTH = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_codec_kind
);

  logic                  step;
  win_ctl_t              win_ctl;
  logic                  res_valid;
  codec_t                res_code;
  codec_t                q_code;
  logic                  q_full;
  logic [SIG_COUNT-1:0]  hits;
  logic [7:0]            cell_byte  [WINDOW_DEPTH+1];
  logic                  cell_valid [WINDOW_DEPTH+1];
  logic [SIG_COUNT-1:0]  cell_hit   [WINDOW_DEPTH];

  assign step          = in_valid && !q_full;
  assign in_stall      = q_full;
  assign cell_byte[0]  = fold_char(in_data_byte);
  assign cell_valid[0] = 1'b1;

  for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
    ocs_cell #(
      .POS(k)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .win_ctl  (win_ctl),
      .byte_in  (cell_byte[k]),
      .valid_in (cell_valid[k]),
      .byte_out (cell_byte[k+1]),
      .valid_out(cell_valid[k+1]),
      .hit      (cell_hit[k])
    );
  end

  always_comb begin
    hits = '1;
    for (int k = 0; k < WINDOW_DEPTH; k++) begin
      hits = hits & cell_hit[k];
    end
  end

  ocs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (step),
    .data_byte(in_data_byte),
    .last_byte(in_last_byte),
    .hits     (hits),
    .win_ctl  (win_ctl),
    .res_valid(res_valid),
    .res_code (res_code)
  );

  ocs_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (res_valid),
    .wr_code  (res_code),
    .rd_en    (!out_stall),
    .full     (q_full),
    .not_empty(out_valid),
    .rd_code  (q_code)
  );

  assign out_codec_kind = q_code;

endmodule

>>> tb/ogg_codec_sniffer_unit_checker.sv
// Scoreboard for the Ogg codec sniffer: predicts codec codes from input beats and checks results.
module ogg_codec_sniffer_unit_checker
  import ocs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [2:0] out_codec_kind,
  input  logic       wrap_up,
  output int         fail_count,
  output int         pending
);

  typedef enum logic [1:0] {PH_HEADER, PH_LACING, PH_PAYLOAD, PH_DROP} page_phase_e;

  localparam logic [31:0] OGG_MAGIC      = "OggS";
  localparam logic [63:0] TAG_OPUS       = "opushead";
  localparam logic [63:0] TAG_VORBIS     = "vorbis";
  localparam logic [63:0] TAG_SPEEX      = "speex";
  localparam logic [63:0] TAG_FLAC       = "flac";
  localparam int          HEADER_SEG_POS = 26;
  localparam int          WIN_LEN        = 8;

  page_phase_e phase;
  logic [4:0]  hdr_cnt;
  logic [7:0]  seg_left;
  logic [15:0] body_left;
  logic [7:0]  win [WIN_LEN];
  logic [3:0]  win_fill;
  logic [3:0]  found;
  codec_t      codec_q[$];
  int          errs;
  bit          closed;

  function automatic void rearm();
    phase = PH_HEADER;
    hdr_cnt = '0;
    seg_left = '0;
    body_left = '0;
    foreach (win[k]) win[k] = '0;
    win_fill = '0;
    found = '0;
  endfunction

  function automatic void conclude(input logic last);
    if (last) begin
      rearm();
    end else begin
      phase = PH_DROP;
    end
  endfunction

  // newest window byte is compared against the low byte of the tag
  function automatic bit tail_is(input logic [63:0] tag, input int len);
    if (win_fill < len) return 1'b0;
    for (int k = 0; k < len; k++) begin
      if (win[k] != tag[8*k +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit sniff_byte(input logic [7:0] b, input logic last,
                                    output codec_t kind);
    kind = CODEC_UNKNOWN;
    case (phase)
      PH_HEADER: begin
        if (hdr_cnt < 4 && b != OGG_MAGIC[31 - 8*int'(hdr_cnt) -: 8]) begin
          conclude(last);
          return 1'b1;
        end
        if (hdr_cnt == HEADER_SEG_POS) begin
          seg_left = b;
          body_left = '0;
          if (b == 8'd0) begin
            conclude(last);
            return 1'b1;
          end
          phase = PH_LACING;
          hdr_cnt = '0;
        end else begin
          hdr_cnt = hdr_cnt + 5'd1;
        end
      end
      PH_LACING: begin
        body_left = body_left + 16'(b);
        seg_left = seg_left - 8'd1;
        if (seg_left == 8'd0) begin
          if (body_left == 16'd0) begin
            conclude(last);
            return 1'b1;
          end
          phase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        for (int k = WIN_LEN - 1; k > 0; k--) win[k] = win[k-1];
        win[0] = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
        if (win_fill < WIN_LEN) win_fill = win_fill + 4'd1;
        if (tail_is(TAG_OPUS, 8)) found[0] = 1'b1;
        if (tail_is(TAG_VORBIS, 6)) found[1] = 1'b1;
        if (tail_is(TAG_SPEEX, 5)) found[2] = 1'b1;
        if (tail_is(TAG_FLAC, 4)) found[3] = 1'b1;
        body_left = body_left - 16'd1;
        if (body_left == 16'd0) begin
          kind = found[0] ? CODEC_OPUS :
                 found[1] ? CODEC_VORBIS :
                 found[2] ? CODEC_SPEEX :
                 found[3] ? CODEC_FLAC : CODEC_UNKNOWN;
          conclude(last);
          return 1'b1;
        end
      end
      default: begin
        if (last) rearm();
        return 1'b0;
      end
    endcase
    if (last) begin
      rearm();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin
    codec_t want;
    codec_t fresh;
    if (!rst_n) begin
      rearm();
      codec_q.delete();
      errs = 0;
      closed = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (codec_q.size() == 0) begin
          $display("%0t: unexpected codec beat: expected none, got %0d",
                   $time, out_codec_kind);
          errs++;
        end else begin
          want = codec_q.pop_front();
          if (out_codec_kind !== want) begin
            $display("%0t: codec mismatch: expected %0d, got %0d",
                     $time, want, out_codec_kind);
            errs++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (sniff_byte(in_data_byte, in_last_byte, fresh)) codec_q.push_back(fresh);
      end
      if (wrap_up && !closed) begin
        closed = 1'b1;
        if (codec_q.size() != 0) begin
          $display("%0t: %0d codec beats missing: expected %0d first, got none",
                   $time, codec_q.size(), codec_q[0]);
          errs += codec_q.size();
        end
      end
    end
    fail_count <= errs;
    pending <= codec_q.size();
  end

endmodule

>>> tb/ogg_codec_sniffer_unit_test.sv
// Top of the Ogg codec sniffer testbench: clock, reset, byte-stream stimulus and verdict.
module ogg_codec_sniffer_unit_test;

  localparam int QUIET_LIMIT = 1000;
  localparam int HOLD_CYCLES = 80;
  localparam int TAIL_CYCLES = 12;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_data_byte;
  logic       in_last_byte;
  logic       out_valid;
  logic       out_stall;
  logic [2:0] out_codec_kind;
  logic       wrap_up;
  logic       hold_req;
  int         fail_count;
  int         pending;
  int         src_idle_pct;
  int         snk_idle_pct;
  int         quiet_cycles;
  int         bytes_sent;
  int         files_sent;
  bit         hold_done;
  logic [7:0] file_q[$];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  ogg_codec_sniffer_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_codec_kind (out_codec_kind)
  );

  ogg_codec_sniffer_unit_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_codec_kind (out_codec_kind),
    .wrap_up        (wrap_up),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_beat(input logic [7:0] d, input logic l);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= d;
    in_last_byte <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic ship();
    foreach (file_q[k]) send_beat(file_q[k], k == file_q.size() - 1);
    file_q.delete();
    files_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] any_case(input logic [7:0] c);
    if (c >= "a" && c <= "z" && $urandom_range(1) == 1) return c - 8'd32;
    return c;
  endfunction

  function automatic void add_text(input string s, input bit mixed);
    for (int k = 0; k < s.len(); k++) begin
      file_q.push_back(mixed ? any_case(s[k]) : s[k]);
    end
  endfunction

  function automatic void add_noise(input int n);
    repeat (n) file_q.push_back(8'($urandom));
  endfunction

  function automatic void add_head(input string magic, input logic [7:0] nseg);
    add_text(magic, 1'b0);
    add_noise(22);
    file_q.push_back(nseg);
  endfunction

  function automatic string pick_tag();
    case ($urandom_range(3))
      0:       return "opushead";
      1:       return "vorbis";
      2:       return "speex";
      default: return "flac";
    endcase
  endfunction

  function automatic void add_random_file();
    int kind;
    int nseg;
    int lace;
    int total;
    int start;
    int cut;
    kind = $urandom_range(99);
    if (kind < 8) begin
      add_noise($urandom_range(1, 6));
      return;
    end
    nseg = ($urandom_range(24) == 0) ? 0 : $urandom_range(1, 3);
    add_head("OggS", 8'(nseg));
    if (kind < 14) file_q[$urandom_range(3)] ^= 8'($urandom_range(1, 255));
    total = 0;
    repeat (nseg) begin
      lace = ($urandom_range(19) == 0) ? 255 : $urandom_range(12);
      file_q.push_back(8'(lace));
      total += lace;
    end
    start = file_q.size();
    while (file_q.size() < start + total) begin
      case ($urandom_range(9))
        0, 1, 2: add_text(pick_tag(), 1'b1);
        3, 4:    file_q.push_back(any_case("a" + 8'($urandom_range(25))));
        default: file_q.push_back(8'($urandom));
      endcase
    end
    while (file_q.size() > start + total) void'(file_q.pop_back());
    if ($urandom_range(6) == 0) begin
      cut = $urandom_range(1, file_q.size());
      while (file_q.size() > cut) void'(file_q.pop_back());
    end else begin
      add_noise($urandom_range(4));
    end
  endfunction

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data_byte <= '0;
    in_last_byte <= 1'b0;
    wrap_up <= 1'b0;
    hold_req <= 1'b0;
    src_idle_pct <= 13;
    snk_idle_pct <= 69;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    file_q.push_back("X");
    ship();
    file_q.push_back("O");
    ship();
    add_text("OggX", 1'b0);
    add_noise(3);
    ship();
    add_text("oggs", 1'b0);
    ship();
    add_head("OggS", 8'd0);
    add_noise(2);
    ship();
    add_head("OggS", 8'd2);
    file_q.push_back(8'd0);
    file_q.push_back(8'd0);
    ship();
    add_head("OggS", 8'd1);
    file_q.push_back(8'd8);
    add_text("OpusHead", 1'b0);
    add_noise(3);
    ship();
    add_head("OggS", 8'd1);
    file_q.push_back(8'd10);
    add_text("xxVORBISyy", 1'b0);
    ship();
    add_head("OggS", 8'd2);
    file_q.push_back(8'd3);
    file_q.push_back(8'd4);
    add_text("sPeExab", 1'b0);
    ship();
    add_head("OggS", 8'd1);
    file_q.push_back(8'd4);
    add_text("flac", 1'b0);
    ship();
    add_head("OggS", 8'd1);
    file_q.push_back(8'd23);
    add_text("flacspeexvorbisopushead", 1'b1);
    ship();
    add_head("OggS", 8'd1);
    file_q.push_back(8'd10);
    add_text("FLACvorbis", 1'b0);
    add_noise(1);
    ship();
    add_text("OggSflacvorbisopusheadxxxx", 1'b0);
    file_q.push_back(8'd1);
    file_q.push_back(8'd2);
    add_text("zz", 1'b0);
    ship();
    add_head("OggS", 8'd1);
    file_q.push_back(8'd3);
    add_text("flac", 1'b0);
    ship();
    add_head("OggS", 8'd1);
    file_q.push_back(8'd4);
    file_q.push_back(8'hC6);
    add_text("lac", 1'b0);
    ship();
    add_head("OggS", 8'd3);
    file_q.push_back(8'd5);
    ship();
    add_head("OggS", 8'd1);
    file_q.push_back(8'd9);
    add_text("opus", 1'b0);
    ship();
    drain();

    for (int p = 0; p < 3; p++) begin
      src_idle_pct <= (p == 0) ? 13 : (p == 1) ? 69 : 0;
      snk_idle_pct <= (p == 0) ? 69 : (p == 1) ? 13 : 0;
      bytes_sent = 0;
      files_sent = 0;
      if (p == 2) begin
        hold_req <= 1'b1;
        repeat (12) begin
          file_q.push_back("X");
          ship();
        end
      end
      while (bytes_sent < 100 || files_sent < 3) begin
        add_random_file();
        ship();
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    wrap_up <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
